[design/sixax_pkg.sv]
`default_nettype none

package sixax_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W     = 34;
  // reduction (7) + CORDIC + sign fix
  localparam int LANE_LAT     = CORDIC_STEPS + 8;
  localparam int MERGE_LAT    = 3;
  localparam int PIPE_LAT     = LANE_LAT + MERGE_LAT;

  localparam logic [35:0] TWO_PI_Q32  = 36'd26986075409;
  localparam logic [35:0] PI_Q32      = 36'd13493037705;
  localparam logic [35:0] HALF_PI_Q32 = 36'd6746518852;
  // floor(2^48 / TWO_PI_Q32)
  localparam logic [13:0] TWO_PI_RECIP = 14'd10430;
  localparam logic [31:0] GAIN_INV_Q30 = 32'd652032874;

  localparam logic [29:0] ATAN_Q30 [31] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
    30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
    30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
    30'd32,        30'd16,        30'd8,         30'd4,         30'd2,
    30'd1
  };

  localparam logic [1:0] CMD_MOTION  = 2'd0;
  localparam logic [1:0] CMD_PRESS   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_OTHER   = 2'd3;

  localparam logic [1:0] KIND_MOTION  = 2'd0;
  localparam logic [1:0] KIND_PRESS   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [1:0] REG_TRANS_SCALE    = 2'd0;
  localparam logic [1:0] REG_ROT_SCALE      = 2'd1;
  localparam logic [1:0] REG_DEVICE_PRESENT = 2'd2;

  localparam logic [23:0] TRANS_SCALE_RST = 24'd16777;
  localparam logic [23:0] ROT_SCALE_RST   = 24'd2928;

  typedef struct packed {
    logic signed [31:0] sn;
    logic signed [31:0] cs;
  } sincos_t;

  typedef struct packed {
    logic signed [17:0] w;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
  } quat_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic [3:0]         bcode;
    logic               bunk;
  } side_t;

  // Q.30 product back to Q.30, half away from zero
  function automatic logic signed [31:0] rnd30(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = v + (v[63] ? 64'sd536870911 : 64'sd536870912);
    return s[61:30];
  endfunction

  // Q.24 translation to Q.16, half away from zero
  function automatic logic signed [31:0] rnd8(input logic signed [41:0] v);
    logic signed [41:0] s;
    s = v + (v[41] ? 42'sd127 : 42'sd128);
    return s[39:8];
  endfunction

  // Q.30 sum to saturated Q1.16
  function automatic logic signed [17:0] rnd14_sat(input logic signed [34:0] v);
    logic signed [34:0] s;
    logic signed [20:0] q;
    s = v + (v[34] ? 35'sd8191 : 35'sd8192);
    q = s[34:14];
    if (q > 21'sd131071) begin
      return 18'sd131071;
    end else if (q < -21'sd131072) begin
      return -18'sd131072;
    end
    return q[17:0];
  endfunction

endpackage

`default_nettype wire

[design/sixax_in_if.sv]
`default_nettype none

interface sixax_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [15:0] trans_x_raw;
  logic signed [15:0] trans_y_raw;
  logic signed [15:0] trans_z_raw;
  logic signed [15:0] roll_raw;
  logic signed [15:0] pitch_raw;
  logic signed [15:0] yaw_raw;
  logic signed [15:0] button_number;

  modport source (output valid, command, trans_x_raw, trans_y_raw, trans_z_raw,
                  roll_raw, pitch_raw, yaw_raw, button_number, input ready);
  modport sink (input valid, command, trans_x_raw, trans_y_raw, trans_z_raw,
                roll_raw, pitch_raw, yaw_raw, button_number, output ready);
endinterface

`default_nettype wire

[design/sixax_out_if.sv]
`default_nettype none

interface sixax_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         event_kind;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  logic signed [31:0] trans_z;
  logic signed [17:0] quat_w;
  logic signed [17:0] quat_x;
  logic signed [17:0] quat_y;
  logic signed [17:0] quat_z;
  logic [3:0]         button_code;
  logic               button_unknown;

  modport source (output valid, event_kind, trans_x, trans_y, trans_z, quat_w, quat_x,
                  quat_y, quat_z, button_code, button_unknown, input ready);
  modport sink (input valid, event_kind, trans_x, trans_y, trans_z, quat_w, quat_x,
                quat_y, quat_z, button_code, button_unknown, output ready);
endinterface

`default_nettype wire

[design/sixax_angle_lane.sv]
`default_nettype none

module sixax_angle_lane import sixax_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] raw_i,
  input  logic [23:0]        scale_i,
  input  logic               neg_i,
  output sincos_t            sc_o
);

  localparam int CW = CORDIC_W;

  logic signed [40:0] prod;
  logic [39:0] mag0_d, mag0_q, mag1_q;
  logic        sgn0_d, sgn0_q, sgn1_q, sgn2_q, sgn3_q;
  logic [41:0] qprod;
  logic [12:0] q1_q;
  logic [47:0] qt;
  logic [35:0] rem2_q;
  logic [34:0] rem3_d, rem3_q;
  logic [33:0] m4_d, m4_q, m5_d, m5_q;
  logic        s4_d, s4_q, s5_d, s5_q, f5_d, f5_q, f6_q;
  logic [31:0] rm;
  logic signed [CW-1:0] z6_d, z6_q;

  logic signed [CW-1:0] cx_q [CORDIC_STEPS];
  logic signed [CW-1:0] cy_q [CORDIC_STEPS];
  logic signed [CW-1:0] cz_q [CORDIC_STEPS];
  logic                 cf_q [CORDIC_STEPS];
  sincos_t              sc_d, sc_q;

  // angle magnitude and sign; yaw lane negates
  assign prod   = raw_i * $signed({1'b0, scale_i});
  assign mag0_d = prod[40] ? 40'(-prod) : prod[39:0];
  assign sgn0_d = prod[40] ^ neg_i;

  // quotient estimate by reciprocal, at most one short
  assign qprod = 42'(mag0_q[39:12]) * 42'(TWO_PI_RECIP);
  assign qt    = 48'(q1_q) * 48'(TWO_PI_Q32);
  assign rem3_d = (rem2_q >= TWO_PI_Q32) ? 35'(rem2_q - TWO_PI_Q32) : rem2_q[34:0];

  // wrap into [-pi, pi] on the magnitude
  always_comb begin
    if (36'(rem3_q) > PI_Q32) begin
      m4_d = 34'(TWO_PI_Q32 - 36'(rem3_q));
      s4_d = ~sgn3_q;
    end else begin
      m4_d = rem3_q[33:0];
      s4_d = sgn3_q;
    end
  end

  // fold by pi beyond +-pi/2
  always_comb begin
    if (36'(m4_q) > HALF_PI_Q32) begin
      m5_d = 34'(PI_Q32 - 36'(m4_q));
      s5_d = ~s4_q;
      f5_d = 1'b1;
    end else begin
      m5_d = m4_q;
      s5_d = s4_q;
      f5_d = 1'b0;
    end
  end

  assign rm   = 32'((35'(m5_q) + 35'd2) >> 2);
  assign z6_d = s5_q ? -$signed(CW'(rm)) : $signed(CW'(rm));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag0_q <= mag0_d;
      sgn0_q <= sgn0_d;
      q1_q   <= qprod[40:28];
      mag1_q <= mag0_q;
      sgn1_q <= sgn0_q;
      rem2_q <= 36'({mag1_q, 8'b0} - qt);
      sgn2_q <= sgn1_q;
      rem3_q <= rem3_d;
      sgn3_q <= sgn2_q;
      m4_q   <= m4_d;
      s4_q   <= s4_d;
      m5_q   <= m5_d;
      s5_q   <= s5_d;
      f5_q   <= f5_d;
      z6_q   <= z6_d;
      f6_q   <= f5_q;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CW-1:0] xi, yi, zi;
    logic                 fi;
    if (i == 0) begin : g_first
      assign xi = $signed(CW'(GAIN_INV_Q30));
      assign yi = '0;
      assign zi = z6_q;
      assign fi = f6_q;
    end else begin : g_rest
      assign xi = cx_q[i-1];
      assign yi = cy_q[i-1];
      assign zi = cz_q[i-1];
      assign fi = cf_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!zi[CW-1]) begin
          cx_q[i] <= xi - (yi >>> i);
          cy_q[i] <= yi + (xi >>> i);
          cz_q[i] <= zi - $signed(CW'(ATAN_Q30[i]));
        end else begin
          cx_q[i] <= xi + (yi >>> i);
          cy_q[i] <= yi - (xi >>> i);
          cz_q[i] <= zi + $signed(CW'(ATAN_Q30[i]));
        end
        cf_q[i] <= fi;
      end
    end
  end

  always_comb begin
    if (cf_q[CORDIC_STEPS-1]) begin
      sc_d.sn = 32'(-cy_q[CORDIC_STEPS-1]);
      sc_d.cs = 32'(-cx_q[CORDIC_STEPS-1]);
    end else begin
      sc_d.sn = 32'(cy_q[CORDIC_STEPS-1]);
      sc_d.cs = 32'(cx_q[CORDIC_STEPS-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_q <= sc_d;
    end
  end

  assign sc_o = sc_q;

endmodule

`default_nettype wire

[design/sixax_quat_merge.sv]
`default_nettype none

module sixax_quat_merge import sixax_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  sincos_t roll_i,
  input  sincos_t pitch_i,
  input  sincos_t yaw_i,
  output quat_t   quat_o
);

  // pair products: 0 cr*cp, 1 sr*sp, 2 sr*cp, 3 cr*sp
  logic signed [63:0] p_q [4];
  sincos_t            yaw_q;
  logic signed [31:0] r [4];
  logic signed [63:0] t_q [8];
  logic signed [31:0] a [8];
  quat_t              quat_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= roll_i.cs * pitch_i.cs;
      p_q[1] <= roll_i.sn * pitch_i.sn;
      p_q[2] <= roll_i.sn * pitch_i.cs;
      p_q[3] <= roll_i.cs * pitch_i.sn;
      yaw_q  <= yaw_i;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      r[k] = rnd30(p_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q[0] <= r[0] * yaw_q.cs;
      t_q[1] <= r[1] * yaw_q.sn;
      t_q[2] <= r[2] * yaw_q.cs;
      t_q[3] <= r[3] * yaw_q.sn;
      t_q[4] <= r[3] * yaw_q.cs;
      t_q[5] <= r[2] * yaw_q.sn;
      t_q[6] <= r[0] * yaw_q.sn;
      t_q[7] <= r[1] * yaw_q.cs;
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      a[k] = rnd30(t_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quat_q.w <= rnd14_sat(35'(a[0]) + 35'(a[1]));
      quat_q.x <= rnd14_sat(35'(a[2]) - 35'(a[3]));
      quat_q.y <= rnd14_sat(35'(a[4]) + 35'(a[5]));
      quat_q.z <= rnd14_sat(35'(a[6]) - 35'(a[7]));
    end
  end

  assign quat_o = quat_q;

endmodule

`default_nettype wire

[design/six_axis_event_to_pose.sv]
`default_nettype none

// Six-axis event to pose: takes one controller event per cycle while the output is
// not held and returns one word per event. Motion events give a scaled translation
// (Q15.16, z negated) and a roll-pitch-yaw quaternion (Q1.16); press and release
// events give a button code; with the device absent or an unknown command the word
// has kind none. Three angle lanes (range reduction plus a fully unrolled CORDIC)
// run side by side and feed a two-multiplier-deep merge. The whole pipeline advances
// whenever the output register is empty or taken, so it sustains one event per
// cycle; a held output stalls every stage. Registers are written over the APB port
// at 0x0 trans_scale, 0x4 rot_scale, 0x8 device_present.
module six_axis_event_to_pose import sixax_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sixax_in_if.sink    evt_i,
  sixax_out_if.source pose_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [23:0] trans_scale_q, rot_scale_q;
  logic        present_q;
  logic        cfg_wr;

  logic                en, acc;
  logic [PIPE_LAT-1:0] vld_q;

  logic [1:0]         kind_d, kind0_q;
  logic [3:0]         bcode_d, bcode0_q;
  logic               bunk_d, bunk0_q, known;
  logic signed [41:0] px_d, py_d, pz_d, px_q, py_q, pz_q;
  side_t              side_d;
  side_t              side_q [PIPE_LAT-1];
  side_t              side_out;

  sincos_t sc_roll, sc_pitch, sc_yaw;
  quat_t   quat;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_scale_q <= TRANS_SCALE_RST;
      rot_scale_q   <= ROT_SCALE_RST;
      present_q     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TRANS_SCALE:    trans_scale_q <= pwdata[23:0];
        REG_ROT_SCALE:      rot_scale_q   <= pwdata[23:0];
        REG_DEVICE_PRESENT: present_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TRANS_SCALE:    prdata = {8'b0, trans_scale_q};
      REG_ROT_SCALE:      prdata = {8'b0, rot_scale_q};
      REG_DEVICE_PRESENT: prdata = {31'b0, present_q};
      default:            prdata = '0;
    endcase
  end

  // pipeline control
  assign en          = !vld_q[PIPE_LAT-1] || pose_o.ready;
  assign acc         = evt_i.valid && en;
  assign evt_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], acc};
    end
  end

  // event decode
  always_comb begin
    if (!present_q) begin
      kind_d = KIND_NONE;
    end else begin
      unique case (evt_i.command)
        CMD_MOTION:  kind_d = KIND_MOTION;
        CMD_PRESS:   kind_d = KIND_PRESS;
        CMD_RELEASE: kind_d = KIND_RELEASE;
        default:     kind_d = KIND_NONE;
      endcase
    end
  end

  assign known = (evt_i.button_number >= 16'sd1) && (evt_i.button_number <= 16'sd9);

  always_comb begin
    bcode_d = 4'd0;
    bunk_d  = 1'b0;
    if (kind_d == KIND_PRESS || kind_d == KIND_RELEASE) begin
      bcode_d = known ? 4'(evt_i.button_number[3:0] - 4'd1) : 4'd0;
      bunk_d  = !known;
    end
  end

  always_comb begin
    px_d = '0;
    py_d = '0;
    pz_d = '0;
    if (kind_d == KIND_MOTION) begin
      px_d = 42'(evt_i.trans_x_raw * $signed({1'b0, trans_scale_q}));
      py_d = 42'(evt_i.trans_y_raw * $signed({1'b0, trans_scale_q}));
      pz_d = 42'(-$signed(17'(evt_i.trans_z_raw)) * $signed({1'b0, trans_scale_q}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind0_q  <= kind_d;
      bcode0_q <= bcode_d;
      bunk0_q  <= bunk_d;
      px_q     <= px_d;
      py_q     <= py_d;
      pz_q     <= pz_d;
    end
  end

  // translation result travels alongside the angle lanes
  always_comb begin
    side_d.kind  = kind0_q;
    side_d.tx    = rnd8(px_q);
    side_d.ty    = rnd8(py_q);
    side_d.tz    = rnd8(pz_q);
    side_d.bcode = bcode0_q;
    side_d.bunk  = bunk0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int k = 1; k < PIPE_LAT - 1; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  sixax_angle_lane u_roll (
    .clk_i   (clk_i),
    .en_i    (en),
    .raw_i   (evt_i.roll_raw),
    .scale_i (rot_scale_q),
    .neg_i   (1'b0),
    .sc_o    (sc_roll)
  );

  sixax_angle_lane u_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .raw_i   (evt_i.pitch_raw),
    .scale_i (rot_scale_q),
    .neg_i   (1'b0),
    .sc_o    (sc_pitch)
  );

  sixax_angle_lane u_yaw (
    .clk_i   (clk_i),
    .en_i    (en),
    .raw_i   (evt_i.yaw_raw),
    .scale_i (rot_scale_q),
    .neg_i   (1'b1),
    .sc_o    (sc_yaw)
  );

  sixax_quat_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (en),
    .roll_i  (sc_roll),
    .pitch_i (sc_pitch),
    .yaw_i   (sc_yaw),
    .quat_o  (quat)
  );

  assign side_out = side_q[PIPE_LAT-2];

  assign pose_o.valid          = vld_q[PIPE_LAT-1];
  assign pose_o.event_kind     = side_out.kind;
  assign pose_o.trans_x        = side_out.tx;
  assign pose_o.trans_y        = side_out.ty;
  assign pose_o.trans_z        = side_out.tz;
  assign pose_o.button_code    = side_out.bcode;
  assign pose_o.button_unknown = side_out.bunk;
  assign pose_o.quat_w = (side_out.kind == KIND_MOTION) ? quat.w : '0;
  assign pose_o.quat_x = (side_out.kind == KIND_MOTION) ? quat.x : '0;
  assign pose_o.quat_y = (side_out.kind == KIND_MOTION) ? quat.y : '0;
  assign pose_o.quat_z = (side_out.kind == KIND_MOTION) ? quat.z : '0;

`ifndef SYNTHESIS
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pose_o.valid && pose_o.event_kind == KIND_NONE |->
      pose_o.trans_x == 0 && pose_o.trans_z == 0 && pose_o.quat_w == 0 &&
      pose_o.button_code == 0 && !pose_o.button_unknown)
    else $error("kind none word carries data");

  a_motion_no_button: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pose_o.valid && pose_o.event_kind == KIND_MOTION |->
      pose_o.button_code == 0 && !pose_o.button_unknown)
    else $error("motion word carries button data");

  a_button_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pose_o.valid |-> pose_o.button_code <= 4'd8)
    else $error("button code out of range");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> vld_q[0])
    else $error("accepted event lost at pipe entry");
`endif

endmodule

`default_nettype wire
